@@ src/knms_pkg.sv @@
package knms_pkg;

  localparam int IN_COORD_W = 12;
  localparam int STRENGTH_W = 8;
  localparam int DIAM_W     = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [STRENGTH_W-1:0] MIN_RESPONSE_RST      = 8'd100;
  localparam logic [DIAM_W-1:0]     KEYPOINT_DIAMETER_RST = 6'd6;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MIN_RESPONSE      = 1'b0,
    REG_KEYPOINT_DIAMETER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IN_COORD_W-1:0] pixel_x;
    logic [IN_COORD_W-1:0] pixel_y;
    logic [STRENGTH_W-1:0] strength;
    logic                  end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [IN_COORD_W-1:0] kp_x;
    logic [IN_COORD_W-1:0] kp_y;
    logic [STRENGTH_W-1:0] kp_strength;
    logic                  none_found;
    logic                  overflowed;
    logic                  last_item;
  } out_item_t;

endpackage

@@ src/keypoint_threshold_nms_table.sv @@
// Keypoint threshold and non-maximum suppression table.
//
// Input: pixels in raster order on in_data, taken at a clock edge with start
// high and busy low. A pixel whose strength exceeds min_response is compared
// with each stored keypoint in table order, one table read and one squaring
// unit shared by diameter, dx and dy. The candidate is appended or dropped
// after the whole walk, or replaces an entry and ends the walk there. A pixel
// below threshold without end_of_frame leaves busy low.
// With end_of_frame the table is read out after the pixel is processed: one
// keypoint per cycle on out_data, marked by out_valid for one cycle, the
// first in the cycle after readout starts; an empty table gives a single
// none_found result. After readout the table and overflow flag are clear.
// The receiver cannot stall: each result is taken in its strobe cycle.
// Configuration: APB registers min_response at 0x0 and keypoint_diameter at
// 0x4, to be written only while busy is low; the block does not enforce it.
// Reset (rst_n low, synchronous) loads the register defaults and empties the
// table; table contents are not cleared, only the entry count.
module keypoint_threshold_nms_table #(
  parameter int MAX_KEYPOINTS = 64,
  parameter int COORD_BITS    = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  knms_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  output knms_pkg::out_item_t                     out_data,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [knms_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [knms_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [knms_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int CW   = COORD_BITS;
  localparam int SW   = knms_pkg::STRENGTH_W;
  localparam int DW   = knms_pkg::DIAM_W;
  localparam int MW   = (CW > DW) ? CW : DW;
  localparam int PW   = 2 * MW;
  localparam int AW   = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
  localparam int CNTW = $clog2(MAX_KEYPOINTS + 1);
  localparam int EW   = 2 * CW + SW;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LIM  = 7'b0000010,
    ST_NEXT = 7'b0000100,
    ST_DX   = 7'b0001000,
    ST_DY   = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_DUMP = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   min_resp_r;
  logic [DW-1:0]   diam_r;
  logic [CW-1:0]   cand_x_r, cand_x_nxt;
  logic [CW-1:0]   cand_y_r, cand_y_nxt;
  logic [SW-1:0]   cand_s_r, cand_s_nxt;
  logic            eof_r, eof_nxt;
  logic            hit_r, hit_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [PW-1:0]   lim_r, lim_nxt;
  logic [PW-1:0]   sq_dx_r, sq_dx_nxt;
  logic [PW-1:0]   sq_dy_r, sq_dy_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_none_r, out_none_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;
  logic [CW-1:0]   rd_x, rd_y;
  logic [SW-1:0]   rd_s;
  logic [CW-1:0]   abs_dx, abs_dy;
  logic [MW-1:0]   mul_op;
  logic [PW-1:0]   mul_prod;
  logic            overlap;
  logic            cfg_wr;
  knms_pkg::cfg_reg_t cfg_sel;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = knms_pkg::cfg_reg_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      knms_pkg::REG_MIN_RESPONSE:      prdata = knms_pkg::APB_DATA_W'(min_resp_r);
      knms_pkg::REG_KEYPOINT_DIAMETER: prdata = knms_pkg::APB_DATA_W'(diam_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_resp_r <= knms_pkg::MIN_RESPONSE_RST;
      diam_r     <= knms_pkg::KEYPOINT_DIAMETER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        knms_pkg::REG_MIN_RESPONSE:      min_resp_r <= pwdata[SW-1:0];
        knms_pkg::REG_KEYPOINT_DIAMETER: diam_r     <= pwdata[DW-1:0];
      endcase
    end
  end

  // entry layout: x, y, strength
  assign rd_x = ram_rdata[EW-1 -: CW];
  assign rd_y = ram_rdata[SW +: CW];
  assign rd_s = ram_rdata[SW-1:0];

  assign abs_dx = (cand_x_r >= rd_x) ? (cand_x_r - rd_x) : (rd_x - cand_x_r);
  assign abs_dy = (cand_y_r >= rd_y) ? (cand_y_r - rd_y) : (rd_y - cand_y_r);

  // shared squaring unit
  always_comb begin
    case (state_r)
      ST_LIM:  mul_op = MW'(diam_r);
      ST_DX:   mul_op = MW'(abs_dx);
      default: mul_op = MW'(abs_dy);
    endcase
  end

  assign mul_prod = PW'(mul_op) * PW'(mul_op);
  assign overlap  = ((PW+1)'(sq_dx_r) + (PW+1)'(sq_dy_r)) < (PW+1)'(lim_r);

  assign ram_wdata = {cand_x_r, cand_y_r, cand_s_r};

  always_comb begin
    state_nxt     = state_r;
    cand_x_nxt    = cand_x_r;
    cand_y_nxt    = cand_y_r;
    cand_s_nxt    = cand_s_r;
    eof_nxt       = eof_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lim_nxt       = lim_r;
    sq_dx_nxt     = sq_dx_r;
    sq_dy_nxt     = sq_dy_r;
    out_valid_nxt = 1'b0;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cand_x_nxt = CW'(in_data.pixel_x);
          cand_y_nxt = CW'(in_data.pixel_y);
          cand_s_nxt = in_data.strength;
          eof_nxt    = in_data.end_of_frame;
          idx_nxt    = '0;
          if (in_data.strength > min_resp_r) begin
            state_nxt = ST_LIM;
          end else if (in_data.end_of_frame) begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_LIM: begin
        lim_nxt   = mul_prod;
        hit_nxt   = 1'b0;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (idx_r < cnt_r) begin
          ram_re    = 1'b1;
          state_nxt = ST_DX;
        end else begin
          // walk finished without a replacement
          if (!hit_r) begin
            if (cnt_r < CNTW'(MAX_KEYPOINTS)) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          idx_nxt   = '0;
          state_nxt = eof_r ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DX: begin
        sq_dx_nxt = mul_prod;
        state_nxt = ST_DY;
      end
      ST_DY: begin
        sq_dy_nxt = mul_prod;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (overlap && (cand_s_r > rd_s)) begin
          ram_we    = 1'b1;
          hit_nxt   = 1'b1;
          idx_nxt   = '0;
          state_nxt = eof_r ? ST_DUMP : ST_IDLE;
        end else begin
          hit_nxt   = hit_r | overlap;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_DUMP: begin
        out_valid_nxt = 1'b1;
        out_ovf_nxt   = ovf_r;
        if (cnt_r == '0) begin
          out_none_nxt = 1'b1;
          out_last_nxt = 1'b1;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          ram_re       = 1'b1;
          out_none_nxt = 1'b0;
          out_last_nxt = ((idx_r + 1'b1) == cnt_r);
          idx_nxt      = idx_r + 1'b1;
          if ((idx_r + 1'b1) == cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_x_r   <= cand_x_nxt;
    cand_y_r   <= cand_y_nxt;
    cand_s_r   <= cand_s_nxt;
    eof_r      <= eof_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
    lim_r      <= lim_nxt;
    sq_dx_r    <= sq_dx_nxt;
    sq_dy_r    <= sq_dy_nxt;
    out_none_r <= out_none_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  knms_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_KEYPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.kp_x        = out_none_r ? '0 : knms_pkg::IN_COORD_W'(rd_x);
    out_data.kp_y        = out_none_r ? '0 : knms_pkg::IN_COORD_W'(rd_y);
    out_data.kp_strength = out_none_r ? '0 : rd_s;
    out_data.none_found  = out_none_r;
    out_data.overflowed  = out_ovf_r;
    out_data.last_item   = out_last_r;
  end

  // results only come out of a readout
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DUMP))
    else $error("result strobe without readout");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_KEYPOINTS))
    else $error("entry count beyond table size");

  // table is empty once the final result of a readout is out
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_item) |-> (cnt_r == '0 && !ovf_r))
    else $error("table not cleared after readout");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.none_found) |-> out_data.last_item)
    else $error("empty-table result not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CMP || state_r == ST_NEXT))
    else $error("table written outside the walk");

endmodule

@@ src/knms_ram.sv @@
module knms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
